@@ rtl/wdt_pkg.sv @@
// ----------------------------------------------------------------------------
// wdt_pkg
// Shared types, register codes and helpers for the watchdog timer.
// ----------------------------------------------------------------------------
package wdt_pkg;

  localparam int COUNT_WIDTH = 31;
  localparam int READ_WIDTH  = 31;
  localparam int PULSE_WIDTH = 9;
  localparam int RANGE_BASE  = 16;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [2:0] REG_CONTROL = 3'd0;
  localparam logic [2:0] REG_RESTART = 3'd1;
  localparam logic [2:0] REG_COUNT   = 3'd2;
  localparam logic [2:0] REG_STATUS  = 3'd3;
  localparam logic [2:0] REG_CLEAR   = 3'd4;

  localparam logic [1:0] CFG_MODE  = 2'd0;
  localparam logic [1:0] CFG_PULSE = 2'd1;
  localparam logic [1:0] CFG_RANGE = 2'd2;

  localparam logic [7:0] RESTART_KEY = 8'h76;

  localparam logic [PULSE_WIDTH-1:0] PULSE_MAX = PULSE_WIDTH'(1) << 8;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] reg_select;
    logic [7:0] write_data;
  } wdt_req_t;

  typedef struct packed {
    logic       response_mode;
    logic [2:0] reset_pulse_code;
    logic [3:0] timeout_range;
  } wdt_cfg_t;

  typedef struct packed {
    logic                  reset_out;
    logic                  irq;
    logic [READ_WIDTH-1:0] read_data;
  } wdt_rsp_t;

  // bit i is set while i < 16 + range; saturates at all ones
  function automatic logic [COUNT_WIDTH-1:0] top_value(input logic [3:0] range);
    logic [COUNT_WIDTH-1:0] top;
    logic [5:0]             lim;
    lim = 6'(RANGE_BASE) + 6'(range);
    for (int i = 0; i < COUNT_WIDTH; i++) begin
      top[i] = (i < int'(lim));
    end
    return top;
  endfunction

  function automatic logic [PULSE_WIDTH-1:0] pulse_len(input logic [2:0] code);
    return PULSE_WIDTH'(1) << (4'(code) + 4'd1);
  endfunction

endpackage

@@ rtl/wdt_core.sv @@
// ----------------------------------------------------------------------------
// wdt_core
// Watchdog state: down counter, enable, pending interrupt and reset pulse.
// ----------------------------------------------------------------------------
module wdt_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_fire,
  input  wdt_pkg::wdt_req_t req,
  input  wdt_pkg::wdt_cfg_t cfg,
  output wdt_pkg::wdt_rsp_t rsp
);

  logic [wdt_pkg::COUNT_WIDTH-1:0] count_r, count_nxt;
  logic                            enabled_r, enabled_nxt;
  logic                            irq_r, irq_nxt;
  logic [wdt_pkg::PULSE_WIDTH-1:0] pulse_r, pulse_nxt;
  logic [wdt_pkg::READ_WIDTH-1:0]  rd;
  logic [wdt_pkg::COUNT_WIDTH-1:0] top;

  assign top = wdt_pkg::top_value(cfg.timeout_range);

  always_comb begin
    count_nxt   = count_r;
    enabled_nxt = enabled_r;
    irq_nxt     = irq_r;
    pulse_nxt   = pulse_r;
    rd          = '0;
    case (req.kind)
      wdt_pkg::KIND_TICK: begin
        if (pulse_r != '0) begin
          pulse_nxt = pulse_r - wdt_pkg::PULSE_WIDTH'(1);
        end
        if (enabled_r) begin
          if (count_r == '0) begin
            if (!cfg.response_mode || irq_r) begin
              pulse_nxt = wdt_pkg::pulse_len(cfg.reset_pulse_code);
            end else begin
              irq_nxt = 1'b1;
            end
            count_nxt = top;
          end else begin
            count_nxt = count_r - wdt_pkg::COUNT_WIDTH'(1);
          end
        end
      end
      wdt_pkg::KIND_WRITE: begin
        case (req.reg_select)
          wdt_pkg::REG_CONTROL: begin
            if (req.write_data[0] && !enabled_r) begin
              enabled_nxt = 1'b1;
              count_nxt   = top;
            end
          end
          wdt_pkg::REG_RESTART: begin
            if (req.write_data == wdt_pkg::RESTART_KEY) begin
              count_nxt = top;
              irq_nxt   = 1'b0;
            end
          end
          default: ;
        endcase
      end
      wdt_pkg::KIND_READ: begin
        case (req.reg_select)
          wdt_pkg::REG_CONTROL: rd = wdt_pkg::READ_WIDTH'({cfg.reset_pulse_code,
                                                          cfg.response_mode, enabled_r});
          wdt_pkg::REG_COUNT:   rd = wdt_pkg::READ_WIDTH'(count_r);
          wdt_pkg::REG_STATUS:  rd = wdt_pkg::READ_WIDTH'(irq_r);
          wdt_pkg::REG_CLEAR:   irq_nxt = 1'b0;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign rsp.read_data = rd;
  assign rsp.irq       = irq_nxt;
  assign rsp.reset_out = (pulse_nxt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= wdt_pkg::top_value(4'd0);
      enabled_r <= 1'b0;
      irq_r     <= 1'b0;
      pulse_r   <= '0;
    end else if (req_fire) begin
      count_r   <= count_nxt;
      enabled_r <= enabled_nxt;
      irq_r     <= irq_nxt;
      pulse_r   <= pulse_nxt;
    end
  end

`ifndef SYNTHESIS
  a_enable_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    enabled_r |=> enabled_r)
    else $error("watchdog enable dropped");

  a_pulse_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pulse_r <= wdt_pkg::PULSE_MAX)
    else $error("reset pulse length out of range");

  a_irq_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(irq_r) |-> $past(req_fire && req.kind == wdt_pkg::KIND_TICK && enabled_r))
    else $error("interrupt raised outside an enabled tick");
`endif

endmodule

@@ rtl/watchdog_timer_apb.sv @@
// An accepted request's result is registered into the output register as the request is accepted.
// Throughput: one request per cycle while the receiver takes results; the output register frees itself as it is taken.
// Reset: synchronous active-low rst_n clears config, enable, interrupt and pulse,
// and loads the counter with the range-zero top value.
// ----------------------------------------------------------------------------
// watchdog_timer_apb
// Watchdog timer with streaming request/result channels and a config port.
// ----------------------------------------------------------------------------
module watchdog_timer_apb (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [2:0] reg_select, [10:3] write_data, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [30:0] read_data, [31] irq, [32] reset_out, rest zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  wdt_pkg::wdt_cfg_t cfg_r;
  wdt_pkg::wdt_req_t req;
  wdt_pkg::wdt_rsp_t rsp;
  wdt_pkg::wdt_rsp_t rsp_r;
  logic              out_valid_r;
  logic              in_fire;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        wdt_pkg::CFG_MODE:  cfg_r.response_mode    <= cfg_data[0];
        wdt_pkg::CFG_PULSE: cfg_r.reset_pulse_code <= cfg_data[2:0];
        wdt_pkg::CFG_RANGE: cfg_r.timeout_range    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign req.kind       = in_tuser;
  assign req.reg_select = in_tdata[2:0];
  assign req.write_data = in_tdata[10:3];

  wdt_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_fire (in_fire),
    .req      (req),
    .cfg      (cfg_r),
    .rsp      (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
    if (in_fire) begin
      rsp_r <= rsp;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, rsp_r.reset_out, rsp_r.irq, rsp_r.read_data};

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_tvalid)
    else $error("accepted request produced no result");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("request stalled with empty output register");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(rsp_r)))
    else $error("stalled result changed");
`endif

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: watchdog timer self-checking testbench
// Drives tick, register write and register read requests into the watchdog,
// keeps its own model of the counter, interrupt and reset pulse, and checks
// every result field by field. Covers the disabled and enabled states, tick
// bursts in both response modes, config extremes, random traffic under
// several idle mixes, and a long receiver hold.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0]      KIND_UNUSED   = 2'd3;
  localparam longint unsigned COUNT_MAX     = (64'd1 << wdt_pkg::COUNT_WIDTH) - 1;
  localparam int              SETTLE_CYCLES = 4;
  localparam int              DRAIN_LIMIT   = 2000;
  localparam int              TICK_BURST    = 24;
  localparam int              PHASE_ITEMS   = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;    // [2:0] reg_select, [10:3] write_data, rest zero
  logic [1:0]  in_tuser = '0;    // [1:0] kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;        // [30:0] read_data, [31] irq, [32] reset_out, rest zero
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [3:0]  cfg_data = '0;

  wdt_pkg::wdt_cfg_t               wd_cfg;
  logic [wdt_pkg::COUNT_WIDTH-1:0] wd_count;
  logic                            wd_enabled;
  logic                            wd_irq;
  logic [wdt_pkg::PULSE_WIDTH-1:0] wd_pulse;

  wdt_pkg::wdt_rsp_t rsp_q[$];
  int       fail_count = 0;
  int       n_requests = 0;
  int       n_results = 0;
  int       n_timeouts = 0;
  int       n_pulses = 0;
  int       n_irqs = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       hold_cycles = 0;
  int       hold_left = 0;

  watchdog_timer_apb dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 2_000_000);
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [wdt_pkg::COUNT_WIDTH-1:0] reload_value();
    longint unsigned top;
    top = (64'd1 << (wdt_pkg::RANGE_BASE + int'(wd_cfg.timeout_range))) - 1;
    if (top > COUNT_MAX) top = COUNT_MAX;
    return wdt_pkg::COUNT_WIDTH'(top);
  endfunction

  function automatic wdt_pkg::wdt_rsp_t apply_request(wdt_pkg::wdt_req_t r);
    wdt_pkg::wdt_rsp_t rsp;
    rsp = '0;
    case (r.kind)
      wdt_pkg::KIND_TICK: begin
        if (wd_pulse != 0) wd_pulse = wd_pulse - 1'b1;
        if (wd_enabled) begin
          if (wd_count == 0) begin
            n_timeouts++;
            if (!wd_cfg.response_mode || wd_irq) begin
              wd_pulse = wdt_pkg::PULSE_WIDTH'(1) << (int'(wd_cfg.reset_pulse_code) + 1);
              n_pulses++;
            end else begin
              wd_irq = 1'b1;
              n_irqs++;
            end
            wd_count = reload_value();
          end else begin
            wd_count = wd_count - 1'b1;
          end
        end
      end
      wdt_pkg::KIND_WRITE: begin
        if (r.reg_select == wdt_pkg::REG_CONTROL) begin
          if (r.write_data[0] && !wd_enabled) begin
            wd_enabled = 1'b1;
            wd_count = reload_value();
          end
        end else if (r.reg_select == wdt_pkg::REG_RESTART &&
                     r.write_data == wdt_pkg::RESTART_KEY) begin
          wd_count = reload_value();
          wd_irq = 1'b0;
        end
      end
      wdt_pkg::KIND_READ: begin
        case (r.reg_select)
          wdt_pkg::REG_CONTROL: rsp.read_data = wdt_pkg::READ_WIDTH'(
                                  {wd_cfg.reset_pulse_code, wd_cfg.response_mode, wd_enabled});
          wdt_pkg::REG_COUNT:   rsp.read_data = wdt_pkg::READ_WIDTH'(wd_count);
          wdt_pkg::REG_STATUS:  rsp.read_data = wdt_pkg::READ_WIDTH'(wd_irq);
          wdt_pkg::REG_CLEAR:   wd_irq = 1'b0;
          default: ;
        endcase
      end
      default: ;
    endcase
    rsp.irq = wd_irq;
    rsp.reset_out = (wd_pulse != 0);
    return rsp;
  endfunction

  initial begin
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_cycles != 0) begin
        hold_left = hold_cycles;
        hold_cycles = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    wdt_pkg::wdt_rsp_t got;
    wdt_pkg::wdt_rsp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[32:0];
      if (rsp_q.size() == 0) begin
        $error("unexpected result: read_data %h irq %b reset_out %b",
               got.read_data, got.irq, got.reset_out);
        fail_count++;
      end else begin
        want = rsp_q.pop_front();
        n_results++;
        if (got.read_data !== want.read_data) begin
          $error("read_data mismatch: expected %h, got %h", want.read_data, got.read_data);
          fail_count++;
        end
        if (got.irq !== want.irq) begin
          $error("irq mismatch: expected %b, got %b", want.irq, got.irq);
          fail_count++;
        end
        if (got.reset_out !== want.reset_out) begin
          $error("reset_out mismatch: expected %b, got %b", want.reset_out, got.reset_out);
          fail_count++;
        end
      end
    end
  end

  task automatic send_req(input logic [1:0] kind, input logic [2:0] sel,
                          input logic [7:0] wdata);
    wdt_pkg::wdt_req_t r;
    r.kind = kind;
    r.reg_select = sel;
    r.write_data = wdata;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {5'b0, wdata, sel};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    rsp_q.push_back(apply_request(r));
    n_requests++;
  endtask

  // drop valid, wait for outstanding results, then let the pipeline empty
  task automatic settle();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while (rsp_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (rsp_q.size() != 0) begin
      $error("%0d results never arrived", rsp_q.size());
      fail_count++;
      rsp_q.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      wdt_pkg::CFG_MODE:  wd_cfg.response_mode = val[0];
      wdt_pkg::CFG_PULSE: wd_cfg.reset_pulse_code = val[2:0];
      wdt_pkg::CFG_RANGE: wd_cfg.timeout_range = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic mode, input logic [2:0] code, input logic [3:0] rng);
    write_reg(wdt_pkg::CFG_MODE, {3'($urandom_range(7)), mode});
    write_reg(wdt_pkg::CFG_PULSE, {1'($urandom_range(1)), code});
    write_reg(wdt_pkg::CFG_RANGE, rng);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic tick_run(input int n);
    for (int i = 0; i < n; i++) begin
      send_req(wdt_pkg::KIND_TICK, 3'($urandom_range(7)), 8'($urandom_range(255)));
    end
  endtask

  task automatic random_request();
    int         pick;
    logic [2:0] sel;
    logic [7:0] d;
    pick = $urandom_range(99);
    sel = 3'($urandom_range(7));
    d = 8'($urandom_range(255));
    if (pick < 45)
      send_req(wdt_pkg::KIND_TICK, sel, d);
    else if (pick < 60)
      send_req(wdt_pkg::KIND_WRITE, wdt_pkg::REG_RESTART,
               ($urandom_range(3) != 0) ? wdt_pkg::RESTART_KEY : d);
    else if (pick < 68)
      send_req(wdt_pkg::KIND_WRITE, wdt_pkg::REG_CONTROL, d);
    else if (pick < 73)
      send_req(wdt_pkg::KIND_WRITE, sel, d);
    else if (pick < 83)
      send_req(wdt_pkg::KIND_READ,
               3'($urandom_range(wdt_pkg::REG_COUNT, wdt_pkg::REG_CLEAR)), d);
    else if (pick < 96)
      send_req(wdt_pkg::KIND_READ, sel, d);
    else
      send_req(KIND_UNUSED, sel, d);
  endtask

  task automatic test_disabled_state();
    set_idling(0, 0);
    tick_run(3);
    for (int s = 0; s < 8; s++) send_req(wdt_pkg::KIND_READ, 3'(s), 8'hFF);
    send_req(wdt_pkg::KIND_WRITE, wdt_pkg::REG_COUNT, 8'hFF);
    send_req(wdt_pkg::KIND_WRITE, wdt_pkg::REG_STATUS, 8'hFF);
    send_req(wdt_pkg::KIND_WRITE, wdt_pkg::REG_CLEAR, 8'hFF);
    send_req(wdt_pkg::KIND_WRITE, 3'(wdt_pkg::REG_CLEAR + 3), 8'hAA);
    send_req(wdt_pkg::KIND_WRITE, wdt_pkg::REG_CONTROL, 8'hFE);
    send_req(wdt_pkg::KIND_WRITE, wdt_pkg::REG_RESTART, 8'h00);
    send_req(KIND_UNUSED, wdt_pkg::REG_COUNT, 8'h55);
    send_req(wdt_pkg::KIND_READ, wdt_pkg::REG_CONTROL, 8'h00);
    send_req(wdt_pkg::KIND_READ, wdt_pkg::REG_COUNT, 8'h00);
    settle();
  endtask

  task automatic test_enable_and_restart();
    set_config(1'b1, 3'd7, 4'd15);
    send_req(wdt_pkg::KIND_READ, wdt_pkg::REG_CONTROL, 8'h00);
    send_req(wdt_pkg::KIND_WRITE, wdt_pkg::REG_RESTART, wdt_pkg::RESTART_KEY);
    send_req(wdt_pkg::KIND_READ, wdt_pkg::REG_COUNT, 8'h00);
    tick_run(2);
    send_req(wdt_pkg::KIND_WRITE, wdt_pkg::REG_CONTROL, 8'h01);
    tick_run(3);
    send_req(wdt_pkg::KIND_READ, wdt_pkg::REG_COUNT, 8'h00);
    send_req(wdt_pkg::KIND_WRITE, wdt_pkg::REG_CONTROL, 8'hFF);
    send_req(wdt_pkg::KIND_READ, wdt_pkg::REG_COUNT, 8'h00);
    send_req(wdt_pkg::KIND_WRITE, wdt_pkg::REG_RESTART, 8'h77);
    send_req(wdt_pkg::KIND_WRITE, wdt_pkg::REG_RESTART, 8'h75);
    send_req(wdt_pkg::KIND_WRITE, wdt_pkg::REG_RESTART, 8'hF6);
    send_req(wdt_pkg::KIND_WRITE, wdt_pkg::REG_RESTART, 8'h00);
    send_req(wdt_pkg::KIND_READ, wdt_pkg::REG_COUNT, 8'h00);
    send_req(wdt_pkg::KIND_READ, wdt_pkg::REG_CONTROL, 8'h00);
    settle();
    // new range applies only at the next reload
    set_config(1'b0, 3'd0, 4'd0);
    send_req(wdt_pkg::KIND_READ, wdt_pkg::REG_COUNT, 8'h00);
    send_req(wdt_pkg::KIND_WRITE, wdt_pkg::REG_RESTART, wdt_pkg::RESTART_KEY);
    send_req(wdt_pkg::KIND_READ, wdt_pkg::REG_COUNT, 8'h00);
    send_req(wdt_pkg::KIND_READ, wdt_pkg::REG_CONTROL, 8'h00);
    settle();
  endtask

  task automatic test_timeouts();
    set_idling(0, 0);
    set_config(1'b0, 3'd7, 4'd0);
    send_req(wdt_pkg::KIND_WRITE, wdt_pkg::REG_RESTART, wdt_pkg::RESTART_KEY);
    tick_run(TICK_BURST);
    send_req(wdt_pkg::KIND_WRITE, wdt_pkg::REG_RESTART, wdt_pkg::RESTART_KEY);
    send_req(wdt_pkg::KIND_READ, wdt_pkg::REG_STATUS, 8'h00);
    tick_run(TICK_BURST);
    send_req(wdt_pkg::KIND_READ, wdt_pkg::REG_COUNT, 8'h00);
    settle();
    set_config(1'b1, 3'd0, 4'd0);
    send_req(wdt_pkg::KIND_WRITE, wdt_pkg::REG_RESTART, wdt_pkg::RESTART_KEY);
    tick_run(TICK_BURST);
    send_req(wdt_pkg::KIND_READ, wdt_pkg::REG_STATUS, 8'h00);
    send_req(wdt_pkg::KIND_READ, wdt_pkg::REG_CLEAR, 8'h00);
    send_req(wdt_pkg::KIND_READ, wdt_pkg::REG_STATUS, 8'h00);
    tick_run(TICK_BURST);
    tick_run(TICK_BURST);
    send_req(wdt_pkg::KIND_READ, wdt_pkg::REG_STATUS, 8'h00);
    tick_run(3);
    send_req(wdt_pkg::KIND_WRITE, wdt_pkg::REG_RESTART, wdt_pkg::RESTART_KEY);
    send_req(wdt_pkg::KIND_READ, wdt_pkg::REG_STATUS, 8'h00);
    settle();
  endtask

  task automatic test_long_hold();
    set_idling(0, 0);
    hold_cycles = 80;
    for (int i = 0; i < 40; i++) random_request();
    settle();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          set_config(1'b0, 3'd0, 4'd0);
          set_idling(0, 0);
        end
        1: begin
          set_config(1'($urandom_range(1)), 3'($urandom_range(7)), 4'($urandom_range(15)));
          set_idling(59, 0);
        end
        2: begin
          set_config(1'($urandom_range(1)), 3'($urandom_range(7)), 4'($urandom_range(15)));
          set_idling(0, 59);
        end
        default: begin
          set_config(1'b1, 3'd7, 4'd15);
          set_idling(20, 20);
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) random_request();
      settle();
    end
  endtask

  initial begin
    wd_cfg = '0;
    wd_enabled = 1'b0;
    wd_irq = 1'b0;
    wd_pulse = '0;
    wd_count = reload_value();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_disabled_state();
    test_enable_and_restart();
    test_timeouts();
    test_long_hold();
    test_random_traffic();
    set_idling(0, 0);
    $display("Covered %0d requests and %0d results over four idle mixes and a long hold",
             n_requests, n_results);
    $display("Timeouts %0d, reset pulses %0d, interrupts %0d", n_timeouts, n_pulses, n_irqs);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ watchdog_timer_apb.f @@
rtl/wdt_pkg.sv
rtl/wdt_core.sv
rtl/watchdog_timer_apb.sv
tb/tb_top.sv
